// File: design/psrl_pkg.sv
// Shared types and constants for the per-source scan rate limiter.
// Used by psrl_ctrl, psrl_dp and per_source_scan_rate_limiter; no dependencies.
package psrl_pkg;

  localparam int unsigned APB_AW = 3;

  localparam logic [7:0]  COUNT_MAX      = 8'hFF;
  localparam logic [7:0]  COUNT_ONE      = 8'd1;
  localparam logic [31:0] WINDOW_LEN_RST = 32'd60;
  localparam logic [7:0]  THRESHOLD_RST  = 8'd2;

  typedef enum logic {
    REG_WINDOW_LEN = 1'b0,
    REG_THRESHOLD  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic id_zero;
    logic hit;
    logic last;
  } dp_status_t;

endpackage

// File: design/psrl_ctrl.sv
// Controller state machine: accept a word, walk the slot table (skipped for a zero key), then update.
// Depends on psrl_pkg; drives psrl_dp through ctrl_cmd_t.
module psrl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  output logic                   done_o,
  input  psrl_pkg::dp_status_t   status_i,
  output psrl_pkg::ctrl_cmd_t    cmd_o
);

  psrl_pkg::state_e state_q, state_d;
  logic             done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      psrl_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.id_zero ? psrl_pkg::ST_UPDATE : psrl_pkg::ST_SCAN;
        end
      end
      psrl_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit || status_i.last) begin
          state_d = psrl_pkg::ST_UPDATE;
        end
      end
      psrl_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = psrl_pkg::ST_IDLE;
      end
      default: begin
        state_d = psrl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psrl_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == psrl_pkg::ST_UPDATE);
    end
  end

  assign busy   = (state_q != psrl_pkg::ST_IDLE);
  assign done_o = done_q;

endmodule

// File: design/psrl_dp.sv
// Datapath: slot table memory with valid bits, scan compare pipeline and
// window update. Depends on psrl_pkg; commanded by psrl_ctrl.
module psrl_dp #(
  parameter int unsigned TABLE_SLOTS = 16,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psrl_pkg::ctrl_cmd_t  cmd_i,
  output psrl_pkg::dp_status_t status_o,
  input  logic [31:0]          source_id_i,
  input  logic [31:0]          now_time_i,
  input  logic [31:0]          window_len_i,
  input  logic [7:0]           threshold_i,
  output logic                 spam_o,
  output logic                 table_full_o,
  output logic [7:0]           window_count_o
);

  localparam int unsigned IDX_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  logic [KEY_WIDTH-1:0] key_mem   [TABLE_SLOTS];
  logic [31:0]          start_mem [TABLE_SLOTS];
  logic [7:0]           cnt_mem   [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid_q;

  logic [KEY_WIDTH-1:0] key_q;
  logic [31:0]          now_q;
  logic                 zero_q;

  logic [IDX_W-1:0]     addr_q;
  logic                 issued_all_q;
  logic                 cmp_vld_q;
  logic                 rd_valid_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [KEY_WIDTH-1:0] rd_key_q;
  logic [31:0]          rd_start_q;
  logic [7:0]           rd_cnt_q;

  logic                 hit_found_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic [31:0]          hit_start_q;
  logic [7:0]           hit_cnt_q;
  logic                 free_found_q;
  logic [IDX_W-1:0]     free_idx_q;

  logic                 issue;
  logic                 hit;
  logic [31:0]          elapsed;
  logic                 restart;
  logic [7:0]           inc_cnt;

  logic                 wr_en;
  logic                 wr_claim;
  logic [IDX_W-1:0]     wr_addr;
  logic [31:0]          wr_start;
  logic [7:0]           wr_cnt;
  logic                 res_spam;
  logic                 res_full;
  logic [7:0]           res_cnt;

  logic                 spam_q;
  logic                 full_q;
  logic [7:0]           count_q;

  assign issue = cmd_i.scan && !issued_all_q;
  assign hit   = cmp_vld_q && rd_valid_q && (rd_key_q == key_q);

  assign status_o.id_zero = (source_id_i == 32'd0);
  assign status_o.hit     = hit;
  assign status_o.last    = cmp_vld_q && (rd_idx_q == LAST_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      issued_all_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        addr_q       <= '0;
        issued_all_q <= 1'b0;
        cmp_vld_q    <= 1'b0;
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        cmp_vld_q <= issue;
        if (issue) begin
          issued_all_q <= (addr_q == LAST_IDX);
          if (addr_q != LAST_IDX) begin
            addr_q <= addr_q + 1'b1;
          end
        end
        if (cmd_i.scan && hit) begin
          hit_found_q <= 1'b1;
        end
        if (cmd_i.scan && cmp_vld_q && !rd_valid_q && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (wr_claim) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // input latch, scan read stage, hit and free capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= KEY_WIDTH'(source_id_i);
      now_q  <= now_time_i;
      zero_q <= (source_id_i == 32'd0);
    end
    if (issue) begin
      rd_valid_q <= valid_q[addr_q];
      rd_idx_q   <= addr_q;
      rd_key_q   <= key_mem[addr_q];
      rd_start_q <= start_mem[addr_q];
      rd_cnt_q   <= cnt_mem[addr_q];
    end
    if (cmd_i.scan && hit && !hit_found_q) begin
      hit_idx_q   <= rd_idx_q;
      hit_start_q <= rd_start_q;
      hit_cnt_q   <= rd_cnt_q;
    end
    if (cmd_i.scan && cmp_vld_q && !rd_valid_q && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
  end

  assign elapsed = now_q - hit_start_q;
  assign restart = (now_q < hit_start_q) || (elapsed >= window_len_i);
  assign inc_cnt = (hit_cnt_q == psrl_pkg::COUNT_MAX) ? psrl_pkg::COUNT_MAX
                                                       : hit_cnt_q + 8'd1;

  always_comb begin
    wr_en    = 1'b0;
    wr_claim = 1'b0;
    wr_addr  = hit_idx_q;
    wr_start = hit_start_q;
    wr_cnt   = inc_cnt;
    res_spam = 1'b0;
    res_full = 1'b0;
    res_cnt  = 8'd0;
    if (cmd_i.update && !zero_q) begin
      if (hit_found_q) begin
        wr_en = 1'b1;
        if (restart) begin
          wr_start = now_q;
          wr_cnt   = psrl_pkg::COUNT_ONE;
          res_cnt  = psrl_pkg::COUNT_ONE;
        end else begin
          res_cnt  = inc_cnt;
          res_spam = (inc_cnt > threshold_i);
        end
      end else if (free_found_q) begin
        wr_en    = 1'b1;
        wr_claim = 1'b1;
        wr_addr  = free_idx_q;
        wr_start = now_q;
        wr_cnt   = psrl_pkg::COUNT_ONE;
        res_cnt  = psrl_pkg::COUNT_ONE;
      end else begin
        res_spam = 1'b1;
        res_full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= key_q;
      start_mem[wr_addr] <= wr_start;
      cnt_mem[wr_addr]   <= wr_cnt;
    end
    if (cmd_i.update) begin
      spam_q  <= res_spam;
      full_q  <= res_full;
      count_q <= res_cnt;
    end
  end

  assign spam_o         = spam_q;
  assign table_full_o   = full_q;
  assign window_count_o = count_q;

endmodule

// File: design/per_source_scan_rate_limiter.sv
// Top level of the per-source scan rate limiter: configuration registers and
// the psrl_ctrl / psrl_dp pair. Depends on psrl_pkg, psrl_ctrl and psrl_dp.
//
// A word is taken when start is high and busy is low; busy stays high while
// the slot table is searched one slot per cycle through a single registered
// read port, ending early when the key is found; a zero key skips the search.
// Each result shows for one cycle with done_o high and cannot be stalled; a
// new word may be started in the cycle the previous result is shown.
// The user must write configuration through the APB port only while busy is
// low; the block itself does not enforce this.
module per_source_scan_rate_limiter #(
  parameter int unsigned TABLE_SLOTS = 16,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  output logic                        done_o,
  input  logic [31:0]                 source_id_i,
  input  logic [31:0]                 now_time_i,
  output logic                        spam_o,
  output logic                        table_full_o,
  output logic [7:0]                  window_count_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psrl_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [31:0]          window_len_q;
  logic [7:0]           threshold_q;
  psrl_pkg::reg_idx_e   reg_idx;
  psrl_pkg::ctrl_cmd_t  cmd;
  psrl_pkg::dp_status_t status;

  assign pready  = 1'b1;
  assign reg_idx = psrl_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= psrl_pkg::WINDOW_LEN_RST;
      threshold_q  <= psrl_pkg::THRESHOLD_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        psrl_pkg::REG_WINDOW_LEN: window_len_q <= pwdata;
        psrl_pkg::REG_THRESHOLD:  threshold_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      psrl_pkg::REG_WINDOW_LEN: prdata = window_len_q;
      psrl_pkg::REG_THRESHOLD:  prdata = {24'd0, threshold_q};
      default:                  prdata = 32'd0;
    endcase
    if (paddr[1:0] != 2'd0) begin
      prdata = 32'd0;
    end
  end

  psrl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  psrl_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .source_id_i    (source_id_i),
    .now_time_i     (now_time_i),
    .window_len_i   (window_len_q),
    .threshold_i    (threshold_q),
    .spam_o         (spam_o),
    .table_full_o   (table_full_o),
    .window_count_o (window_count_o)
  );

endmodule
